// ===== design/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser: shared types and constants
// Widths, phase and status codes, parse state and result structures used by
// the interfaces and by every module of the parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    // Request, headers and body must fit in this many bytes.
    localparam int WINDOW_BYTES = 65536;

    // Byte offsets run from 0 up to WINDOW_BYTES inclusive.
    localparam int POS_W = $clog2(WINDOW_BYTES + 1);
    // Room for a length times ten plus one digit before saturation.
    localparam int ACC_W = POS_W + 4;
    // Header name index saturates at its all-ones value.
    localparam int NIDX_W = 5;

    // Result field widths.
    localparam int STATUS_W = 2;
    localparam int HDR_W    = 17;
    localparam int LEN_W    = 16;
    localparam int CLEN_W   = 17;

    // Verdict codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_MALFORMED = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_LEN_REQ   = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = STATUS_W'(3);

    // Characters of interest.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Header name candidates, one bit each.
    localparam logic [2:0] M_NONE = 3'b000;
    localparam logic [2:0] M_CL   = 3'b001;
    localparam logic [2:0] M_CT   = 3'b010;
    localparam logic [2:0] M_TE   = 3'b100;
    localparam logic [2:0] M_ALL  = 3'b111;

    typedef enum logic [2:0] {
        PH_REQ,
        PH_NAME,
        PH_SKIP,
        PH_VALUE,
        PH_DONE
    } phase_t;

    // Parse state touched by the per-byte scanner.
    typedef struct packed {
        phase_t             phase;
        logic               bad;
        logic               sp1;
        logic               sp2;
        logic               chunk;
        logic               digit;
        logic [POS_W-1:0]   first_space;
        logic [POS_W-1:0]   target_count;
        logic [NIDX_W-1:0]  name_index;
        logic [2:0]         match;
        logic [POS_W-1:0]   len_acc;
        logic [POS_W-1:0]   type_start;
    } parse_t;

    localparam parse_t PARSE_RESET = '{phase: PH_REQ, match: M_ALL, default: '0};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HDR_W-1:0]    header_bytes;
        logic [LEN_W-1:0]    method_length;
        logic [LEN_W-1:0]    target_length;
        logic [CLEN_W-1:0]   content_length;
        logic [LEN_W-1:0]    type_offset;
        logic [LEN_W-1:0]    type_length;
        logic                type_present;
    } result_t;

endpackage

// ===== design/hrp_if.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser: channel interfaces
// Valid/ready channels for request bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface hrp_in_if;
    import hrp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface hrp_out_if;
    import hrp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HDR_W-1:0]    header_bytes;
    logic [LEN_W-1:0]    method_length;
    logic [LEN_W-1:0]    target_length;
    logic [CLEN_W-1:0]   content_length;
    logic [LEN_W-1:0]    type_offset;
    logic [LEN_W-1:0]    type_length;
    logic                type_present;

    modport source (
        output valid, output status, output header_bytes, output method_length,
        output target_length, output content_length, output type_offset,
        output type_length, output type_present, input ready
    );
    modport sink (
        input valid, input status, input header_bytes, input method_length,
        input target_length, input content_length, input type_offset,
        input type_length, input type_present, output ready
    );
endinterface

// ===== design/hrp_feed.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser: byte scanner
// Advances the parse state by one content byte (request line, header name
// match, value skip and Content-Length digits).
// ----------------------------------------------------------------------------
module hrp_feed (
    input  logic                     en,
    input  logic [7:0]               ch,
    input  logic [hrp_pkg::POS_W-1:0] pos,
    input  hrp_pkg::parse_t          cur,
    output hrp_pkg::parse_t          nxt
);
    import hrp_pkg::*;

    localparam logic [NIDX_W-1:0] CL_LEN = NIDX_W'(14);
    localparam logic [NIDX_W-1:0] CT_LEN = NIDX_W'(12);
    localparam logic [NIDX_W-1:0] TE_LEN = NIDX_W'(17);

    localparam logic [7:0] CL_NAME [14] = '{
        "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
    };
    localparam logic [7:0] CT_NAME [12] = '{
        "c", "o", "n", "t", "e", "n", "t", "-", "t", "y", "p", "e"
    };
    localparam logic [7:0] TE_NAME [17] = '{
        "t", "r", "a", "n", "s", "f", "e", "r", "-",
        "e", "n", "c", "o", "d", "i", "n", "g"
    };

    // Letters compare without case; the dash must match exactly.
    function automatic logic name_eq(input logic [7:0] c, input logic [7:0] e);
        if (e == CH_DASH)
        begin
            return c == CH_DASH;
        end
        return (c | 8'h20) == e;
    endfunction

    logic              is_space;
    logic              is_digit;
    logic              cl_hit;
    logic              ct_hit;
    logic              te_hit;
    logic              take_value;
    logic [2:0]        keep;
    logic [3:0]        digit_val;
    logic [ACC_W-1:0]  acc_mul;
    logic [POS_W-1:0]  acc_sat;

    always_comb
    begin
        is_space  = ch == CH_SPACE;
        is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
        digit_val = 4'(ch - CH_ZERO);
        acc_mul   = (ACC_W'(cur.len_acc) << 3) + (ACC_W'(cur.len_acc) << 1)
                  + ACC_W'(digit_val);
        acc_sat   = (acc_mul > ACC_W'(WINDOW_BYTES)) ? POS_W'(WINDOW_BYTES)
                                                     : POS_W'(acc_mul);

        cl_hit = (cur.name_index < CL_LEN) && name_eq(ch, CL_NAME[cur.name_index[3:0]]);
        ct_hit = (cur.name_index < CT_LEN) && name_eq(ch, CT_NAME[cur.name_index[3:0]]);
        te_hit = (cur.name_index < TE_LEN) && name_eq(ch, TE_NAME[cur.name_index]);

        if (cur.match[0] && (cur.name_index == CL_LEN))
        begin
            keep = M_CL;
        end
        else if (cur.match[1] && (cur.name_index == CT_LEN))
        begin
            keep = M_CT;
        end
        else if (cur.match[2] && (cur.name_index == TE_LEN))
        begin
            keep = M_TE;
        end
        else
        begin
            keep = M_NONE;
        end

        take_value = en && (((cur.phase == PH_SKIP) && !is_space) || (cur.phase == PH_VALUE));

        nxt = cur;
        if (en)
        begin
            case (cur.phase)
                PH_REQ:
                begin
                    if (!cur.sp1)
                    begin
                        if (is_space)
                        begin
                            nxt.sp1         = 1'b1;
                            nxt.first_space = pos;
                        end
                    end
                    else if (!cur.sp2)
                    begin
                        if (is_space)
                        begin
                            nxt.sp2 = 1'b1;
                        end
                        else
                        begin
                            nxt.target_count = cur.target_count + 1'b1;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (ch == CH_COLON)
                    begin
                        nxt.match = keep;
                        nxt.phase = PH_SKIP;
                        if (keep == M_CL)
                        begin
                            nxt.len_acc = '0;
                            nxt.digit   = 1'b0;
                        end
                    end
                    else
                    begin
                        nxt.match = cur.match & {te_hit, ct_hit, cl_hit};
                        if (cur.name_index != '1)
                        begin
                            nxt.name_index = cur.name_index + 1'b1;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (!is_space)
                    begin
                        nxt.phase = PH_VALUE;
                        if (cur.match == M_CT)
                        begin
                            nxt.type_start = pos;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Content-Length value: digits accumulate, anything else is malformed.
        if (take_value && (cur.match == M_CL))
        begin
            if (is_digit)
            begin
                nxt.len_acc = acc_sat;
                nxt.digit   = 1'b1;
            end
            else
            begin
                nxt.bad = 1'b1;
            end
        end
    end

endmodule

// ===== design/hrp_core.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser: state and verdict logic
// Holds the parse state, tracks CR LF progress, closes lines and forms the
// verdict at header end or when the window runs out.
// ----------------------------------------------------------------------------
module hrp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              first,
    output logic              emit,
    output hrp_pkg::result_t  result
);
    import hrp_pkg::*;

    typedef enum logic [1:0] {
        CR_NONE,
        CR_SEEN,
        CR_LF,
        CR_LF_CR
    } crlf_t;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    crlf_t            crlf_reg;
    crlf_t            crlf_next;
    parse_t           parse_reg;
    parse_t           parse_next;
    logic [POS_W-1:0] type_count_reg;
    logic [POS_W-1:0] type_count_next;
    logic             type_seen_reg;
    logic             type_seen_next;

    logic [POS_W-1:0] base_pos;
    crlf_t            base_crlf;
    parse_t           base_parse;
    logic [POS_W-1:0] base_tcount;
    logic             base_tseen;

    logic             cr_pending;
    logic             lf_end;
    logic             hdr_end;
    logic             win_end;
    logic             active;
    logic [POS_W-1:0] cr_pos;
    logic [POS_W-1:0] hb;
    parse_t           after_cr;
    parse_t           after_ch;
    parse_t           ended;
    logic [POS_W-1:0] tcount_end;
    logic             tseen_end;

    // A held CR is scanned first, then the new byte, in the same cycle.
    hrp_feed u_feed_cr (
        .en  (cr_pending),
        .ch  (CH_CR),
        .pos (cr_pos),
        .cur (base_parse),
        .nxt (after_cr)
    );

    hrp_feed u_feed_ch (
        .en  (1'b1),
        .ch  (data_byte),
        .pos (base_pos),
        .cur (after_cr),
        .nxt (after_ch)
    );

    always_comb
    begin
        // A first byte restarts the parser before it is looked at.
        if (first)
        begin
            base_pos    = '0;
            base_crlf   = CR_NONE;
            base_parse  = PARSE_RESET;
            base_tcount = '0;
            base_tseen  = 1'b0;
        end
        else
        begin
            base_pos    = pos_reg;
            base_crlf   = crlf_reg;
            base_parse  = parse_reg;
            base_tcount = type_count_reg;
            base_tseen  = type_seen_reg;
        end

        cr_pending = (base_crlf == CR_SEEN) || (base_crlf == CR_LF_CR);
        lf_end     = (data_byte == CH_LF) && cr_pending;
        hdr_end    = lf_end && (base_crlf == CR_LF_CR);
        cr_pos     = base_pos - 1'b1;
        hb         = base_pos + 1'b1;
        win_end    = !hdr_end && (hb >= POS_W'(WINDOW_BYTES));
        active     = step && (base_parse.phase != PH_DONE);

        // Line close at CR LF.
        ended      = base_parse;
        tcount_end = base_tcount;
        tseen_end  = base_tseen;
        case (base_parse.phase)
            PH_REQ:
            begin
                if (!base_parse.sp1 || (base_parse.first_space == '0)
                    || !base_parse.sp2 || (base_parse.target_count == '0))
                begin
                    ended.bad = 1'b1;
                end
            end
            PH_SKIP, PH_VALUE:
            begin
                if ((base_parse.match == M_CL) && !base_parse.digit)
                begin
                    ended.bad = 1'b1;
                end
                if (base_parse.match == M_CT)
                begin
                    if (base_parse.phase == PH_SKIP)
                    begin
                        ended.type_start = cr_pos;
                    end
                    tcount_end = cr_pos - ended.type_start;
                    tseen_end  = 1'b1;
                end
                if (base_parse.match == M_TE)
                begin
                    ended.chunk = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        ended.phase      = PH_NAME;
        ended.name_index = '0;
        ended.match      = M_ALL;

        // Next state.
        pos_next        = pos_reg;
        crlf_next       = crlf_reg;
        parse_next      = parse_reg;
        type_count_next = type_count_reg;
        type_seen_next  = type_seen_reg;
        if (step)
        begin
            pos_next        = base_pos;
            crlf_next       = base_crlf;
            parse_next      = base_parse;
            type_count_next = base_tcount;
            type_seen_next  = base_tseen;
            if (active)
            begin
                pos_next = hb;
                if (lf_end)
                begin
                    parse_next      = ended;
                    type_count_next = tcount_end;
                    type_seen_next  = tseen_end;
                    crlf_next       = hdr_end ? CR_NONE : CR_LF;
                    if (hdr_end)
                    begin
                        parse_next.phase = PH_DONE;
                    end
                end
                else if (data_byte == CH_CR)
                begin
                    parse_next = after_cr;
                    crlf_next  = (base_crlf == CR_LF) ? CR_LF_CR : CR_SEEN;
                end
                else
                begin
                    parse_next = after_ch;
                    crlf_next  = CR_NONE;
                end
                if (win_end)
                begin
                    parse_next.phase = PH_DONE;
                end
            end
        end

        // Verdict.
        emit   = active && (hdr_end || win_end);
        result = '0;
        if (hdr_end)
        begin
            result.header_bytes = HDR_W'(hb);
            if (ended.bad)
            begin
                result.status = ST_MALFORMED;
            end
            else
            begin
                if (ended.chunk)
                begin
                    result.status = ST_LEN_REQ;
                end
                else if (ended.len_acc > (POS_W'(WINDOW_BYTES) - hb))
                begin
                    result.status = ST_TOO_LARGE;
                end
                else
                begin
                    result.status = ST_ACCEPTED;
                end
                result.method_length  = LEN_W'(ended.first_space);
                result.target_length  = LEN_W'(ended.target_count);
                result.content_length = CLEN_W'(ended.len_acc);
                result.type_offset    = LEN_W'(ended.type_start);
                result.type_length    = LEN_W'(tcount_end);
                result.type_present   = tseen_end;
            end
        end
        else
        begin
            result.status = ST_TOO_LARGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crlf_reg       <= CR_NONE;
            parse_reg      <= PARSE_RESET;
            type_count_reg <= '0;
            type_seen_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crlf_reg       <= crlf_next;
            parse_reg      <= parse_next;
            type_count_reg <= type_count_next;
            type_seen_reg  <= type_seen_next;
        end
    end

endmodule

// ===== design/http_request_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser unit
// Scans request bytes for the end of the headers and reports one verdict
// with the request line split and the Content-Length and Content-Type facts.
// ----------------------------------------------------------------------------
// The parser takes one request byte per clock cycle, sustained, and never
// needs a gap between bytes while the verdict side keeps up: each transfer on
// the request channel is processed while it sits in the input register, by a
// single state update in hrp_core, and that state loop is what sets the rate.
// A verdict, for the byte that ends the headers (the LF of the first CR LF CR
// LF) or for the byte that fills the window, is held in the result register
// and shown from there on the verdict channel. While a verdict waits in the
// result register the core does not step: the next byte stays in the input
// register and the request channel stalls until the verdict transfer. Raise
// first with the first byte of every request; after reset the parser already
// waits at offset zero. After a verdict, bytes are swallowed without result
// until first is seen. The window is WINDOW_BYTES bytes; there is no memory
// and no start-up pass.
// ----------------------------------------------------------------------------
module http_request_header_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    hrp_in_if.sink    request,
    hrp_out_if.source verdict
);
    import hrp_pkg::*;

    // Input register: holds one accepted byte until the core takes it.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    // Result register: holds one verdict until the downstream transfer.
    logic       res_valid_reg;
    logic       res_valid_next;
    result_t    res_reg;

    logic       fire;
    logic       core_emit;
    result_t    core_result;

    // The core steps whenever a byte is waiting and a verdict it may produce
    // has somewhere to go.
    assign fire          = in_valid_reg && (!res_valid_reg || verdict.ready);
    assign request.ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next  = request.ready ? request.valid : in_valid_reg;
        res_valid_next = (res_valid_reg && !verdict.ready) || (fire && core_emit);
    end

    hrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .data_byte (in_byte_reg),
        .first     (in_first_reg),
        .emit      (core_emit),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_byte_reg  <= request.data_byte;
            in_first_reg <= request.first;
        end
        if (fire && core_emit)
        begin
            res_reg <= core_result;
        end
    end

    assign verdict.valid          = res_valid_reg;
    assign verdict.status         = res_reg.status;
    assign verdict.header_bytes   = res_reg.header_bytes;
    assign verdict.method_length  = res_reg.method_length;
    assign verdict.target_length  = res_reg.target_length;
    assign verdict.content_length = res_reg.content_length;
    assign verdict.type_offset    = res_reg.type_offset;
    assign verdict.type_length    = res_reg.type_length;
    assign verdict.type_present   = res_reg.type_present;

    // A byte waiting in the input register is never overwritten before the
    // core has taken it.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost before processing");

    // An accepted body always fits in what the headers leave of the window.
    a_body_fits: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid && (verdict.status == ST_ACCEPTED)
        |-> (int'(verdict.content_length) + int'(verdict.header_bytes) <= WINDOW_BYTES))
        else $error("accepted verdict with a body beyond the window");

    // A malformed verdict carries nothing but the header byte count.
    a_malformed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid && (verdict.status == ST_MALFORMED)
        |-> (verdict.method_length == '0) && (verdict.target_length == '0)
            && (verdict.content_length == '0) && (verdict.type_present == 1'b0))
        else $error("malformed verdict with nonzero fields");

    // A header end needs at least the four bytes of the blank line.
    a_min_header: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid && (verdict.header_bytes != '0)
        |-> (verdict.header_bytes >= HDR_W'(4)))
        else $error("header end reported before four bytes");

endmodule

// ===== tb/hrp_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser: verdict checker
// Watches both channels, runs its own byte-level model of the parser on every
// accepted request byte and compares each verdict transfer field by field
// with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module hrp_verdict_checker
    import hrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hrp_in_if    request,
    hrp_out_if   verdict,
    output int   fail_count,
    output int   pending_verdicts
);
    timeunit 1ns;
    timeprecision 1ps;

    // Progress through CR LF CR LF.
    typedef enum logic [1:0] {
        EOL_NONE,
        EOL_CR,
        EOL_CRLF,
        EOL_CRLF_CR
    } eol_t;

    string cl_text = "content-length";
    string ct_text = "content-type";
    string te_text = "transfer-encoding";

    phase_t            phase;
    eol_t              eol;
    logic [POS_W-1:0]  byte_pos;
    logic [POS_W-1:0]  first_space;
    logic [POS_W-1:0]  target_cnt;
    logic [POS_W-1:0]  len_acc;
    logic [POS_W-1:0]  type_start;
    logic [POS_W-1:0]  type_cnt;
    logic [NIDX_W-1:0] name_idx;
    logic [2:0]        cand;
    logic              bad;
    logic              sp1;
    logic              sp2;
    logic              chunk;
    logic              digit;
    logic              type_seen;

    result_t expected_verdicts[$];
    result_t predicted;

    function automatic void restart_parse();
        phase       = PH_REQ;
        eol         = EOL_NONE;
        byte_pos    = '0;
        first_space = '0;
        target_cnt  = '0;
        len_acc     = '0;
        type_start  = '0;
        type_cnt    = '0;
        name_idx    = '0;
        cand        = M_ALL;
        bad         = 1'b0;
        sp1         = 1'b0;
        sp2         = 1'b0;
        chunk       = 1'b0;
        digit       = 1'b0;
        type_seen   = 1'b0;
    endfunction

    // True when byte c rules out the candidate name s at the current index.
    function automatic bit name_miss(string s, logic [7:0] c);
        if (name_idx >= s.len())
            return 1'b1;
        if (s[name_idx] == CH_DASH)
            return c != CH_DASH;
        return (c | 8'h20) != s[name_idx];
    endfunction

    function automatic void value_char(logic [7:0] c);
        logic [ACC_W-1:0] wide;
        if (cand == M_CL)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                wide = ACC_W'(len_acc) * 10 + ACC_W'(c - CH_ZERO);
                if (wide > ACC_W'(WINDOW_BYTES))
                    wide = ACC_W'(WINDOW_BYTES);
                len_acc = wide[POS_W-1:0];
                digit   = 1'b1;
            end
            else
                bad = 1'b1;
        end
    endfunction

    function automatic void scan_char(logic [7:0] c, logic [POS_W-1:0] p);
        logic [2:0] drop;
        case (phase)
            PH_REQ:
            begin
                if (!sp1)
                begin
                    if (c == CH_SPACE)
                    begin
                        sp1         = 1'b1;
                        first_space = p;
                    end
                end
                else if (!sp2)
                begin
                    if (c == CH_SPACE)
                        sp2 = 1'b1;
                    else
                        target_cnt++;
                end
            end
            PH_NAME:
            begin
                if (c == CH_COLON)
                begin
                    drop = M_NONE;
                    if ((cand & M_CL) != M_NONE && name_idx == cl_text.len())
                        drop = M_CL;
                    else if ((cand & M_CT) != M_NONE && name_idx == ct_text.len())
                        drop = M_CT;
                    else if ((cand & M_TE) != M_NONE && name_idx == te_text.len())
                        drop = M_TE;
                    // Here drop holds the surviving candidate, if any.
                    cand = drop;
                    if (cand == M_CL)
                    begin
                        len_acc = '0;
                        digit   = 1'b0;
                    end
                    phase = PH_SKIP;
                end
                else
                begin
                    drop = M_NONE;
                    if (name_miss(cl_text, c))
                        drop |= M_CL;
                    if (name_miss(ct_text, c))
                        drop |= M_CT;
                    if (name_miss(te_text, c))
                        drop |= M_TE;
                    cand &= ~drop;
                    if (name_idx != {NIDX_W{1'b1}})
                        name_idx++;
                end
            end
            PH_SKIP:
            begin
                if (c != CH_SPACE)
                begin
                    phase = PH_VALUE;
                    if (cand == M_CT)
                        type_start = p;
                    value_char(c);
                end
            end
            PH_VALUE:
                value_char(c);
            default:
                ;
        endcase
    endfunction

    function automatic void close_line(logic [POS_W-1:0] crpos);
        if (phase == PH_REQ)
        begin
            if (!sp1 || first_space == '0 || !sp2 || target_cnt == '0)
                bad = 1'b1;
        end
        else if (phase == PH_SKIP || phase == PH_VALUE)
        begin
            if (cand == M_CL && !digit)
                bad = 1'b1;
            if (cand == M_CT)
            begin
                if (phase == PH_SKIP)
                    type_start = crpos;
                type_cnt  = crpos - type_start;
                type_seen = 1'b1;
            end
            if (cand == M_TE)
                chunk = 1'b1;
        end
        phase    = PH_NAME;
        name_idx = '0;
        cand     = M_ALL;
    endfunction

    // Advances the model by one request byte; returns 1 with the verdict in r
    // when this byte ends the headers or fills the window.
    function automatic bit parse_byte(logic [7:0] c, logic restart, output result_t r);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] hb;
        eol_t             prev;
        r = '0;
        if (restart)
            restart_parse();
        if (phase == PH_DONE)
            return 1'b0;
        pos      = byte_pos;
        prev     = eol;
        byte_pos = pos + 1'b1;
        if (c == CH_LF && (prev == EOL_CR || prev == EOL_CRLF_CR))
        begin
            close_line(pos - 1'b1);
            if (prev == EOL_CRLF_CR)
            begin
                hb    = pos + 1'b1;
                phase = PH_DONE;
                eol   = EOL_NONE;
                r.header_bytes = hb;
                if (bad)
                begin
                    r.status = ST_MALFORMED;
                    return 1'b1;
                end
                if (chunk)
                    r.status = ST_LEN_REQ;
                else if (len_acc > WINDOW_BYTES - hb)
                    r.status = ST_TOO_LARGE;
                else
                    r.status = ST_ACCEPTED;
                r.method_length  = first_space[LEN_W-1:0];
                r.target_length  = target_cnt[LEN_W-1:0];
                r.content_length = len_acc;
                r.type_offset    = type_start[LEN_W-1:0];
                r.type_length    = type_cnt[LEN_W-1:0];
                r.type_present   = type_seen;
                return 1'b1;
            end
            eol = EOL_CRLF;
        end
        else
        begin
            // A CR that was held back and is not followed by LF is plain content.
            if (prev == EOL_CR || prev == EOL_CRLF_CR)
                scan_char(CH_CR, pos - 1'b1);
            if (c == CH_CR)
                eol = (prev == EOL_CRLF) ? EOL_CRLF_CR : EOL_CR;
            else
            begin
                scan_char(c, pos);
                eol = EOL_NONE;
            end
        end
        if (pos + 1 >= WINDOW_BYTES)
        begin
            phase    = PH_DONE;
            r        = '0;
            r.status = ST_TOO_LARGE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("verdict field %s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_parse();
            expected_verdicts.delete();
            fail_count       = 0;
            pending_verdicts = 0;
        end
        else
        begin
            if (verdict.valid && verdict.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("verdict transfer with none outstanding: status %0d header_bytes %0d",
                           verdict.status, verdict.header_bytes);
                    fail_count++;
                end
                else
                begin
                    predicted = expected_verdicts.pop_front();
                    compare_field("status", predicted.status, verdict.status);
                    compare_field("header_bytes", predicted.header_bytes, verdict.header_bytes);
                    compare_field("method_length", predicted.method_length,
                                  verdict.method_length);
                    compare_field("target_length", predicted.target_length,
                                  verdict.target_length);
                    compare_field("content_length", predicted.content_length,
                                  verdict.content_length);
                    compare_field("type_offset", predicted.type_offset, verdict.type_offset);
                    compare_field("type_length", predicted.type_length, verdict.type_length);
                    compare_field("type_present", predicted.type_present,
                                  verdict.type_present);
                end
            end
            if (request.valid && request.ready)
            begin
                if (parse_byte(request.data_byte, request.first, predicted))
                    expected_verdicts.push_back(predicted);
            end
            pending_verdicts = expected_verdicts.size();
        end
    end

endmodule

// ===== tb/tb_http_request_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser unit: testbench top
// Streams directed and random HTTP requests into the parser one byte per
// transfer, with random gaps on the request side and random stalls on the
// verdict side, and reports the outcome of the checker at the end.
// ----------------------------------------------------------------------------
module tb_http_request_header_parser_unit;
    import hrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transfer before the run is declared hung. Random
    // gaps and stalls never come close to this.
    localparam int WATCHDOG_LIMIT = 4000;
    // The verdict for a byte passes only the input and the result register, so a
    // few cycles after the last expected verdict are enough to catch a stray one.
    localparam int DRAIN_CYCLES = 8;
    // Random stimulus per idling mode: stop after this many bytes once enough
    // verdicts have come back as well.
    localparam int RANDOM_BYTES_PER_MODE = 280;
    localparam int VERDICTS_PER_MODE     = 5;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hrp_in_if  request_ch ();
    hrp_out_if verdict_ch ();

    int fail_count;
    int pending_verdicts;

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int send_idle;
    int recv_idle;

    int bytes_sent;
    int verdicts_seen = 0;
    int stall_cycles  = 0;

    // Bytes of the request currently being assembled.
    logic [7:0] request_bytes[$];

    // Header names that miss the three recognized ones, most of them by little.
    string near_names[6] = '{"Host", "Content-Lengt", "Content-Lengthh", "Content_Type",
                             "Transfer-Encodin", "X-Content-Length"};

    http_request_header_parser_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch.sink),
        .verdict (verdict_ch.source)
    );

    hrp_verdict_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .request          (request_ch),
        .verdict          (verdict_ch),
        .fail_count       (fail_count),
        .pending_verdicts (pending_verdicts)
    );

    always #10 clk = ~clk;

    // The verdict receiver decides on every falling edge whether it takes a
    // verdict in the coming cycle. It stays stalled throughout reset.
    always @(negedge clk)
        verdict_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);

    // Counts verdict transfers for the stop condition of the random part and
    // ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (verdict_ch.valid && verdict_ch.ready)
            verdicts_seen <= verdicts_seen + 1;
        if (!rst_n || (request_ch.valid && request_ch.ready)
            || (verdict_ch.valid && verdict_ch.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Appends text to the request. Since string literals have no escape for
    // a carriage return, '~' stands for CR and '^' for LF.
    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == "~")
                request_bytes.push_back(CH_CR);
            else if (s[i] == "^")
                request_bytes.push_back(CH_LF);
            else
                request_bytes.push_back(s[i]);
        end
    endtask

    task automatic put_fill(logic [7:0] ch, int count);
        repeat (count) request_bytes.push_back(ch);
    endtask

    // Appends a header name with the case of each letter picked at random,
    // since the parser has to match names regardless of case.
    task automatic put_name(string s);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if ((ch | 8'h20) >= "a" && (ch | 8'h20) <= "z" && $urandom_range(1) == 1)
                ch ^= 8'h20;
            request_bytes.push_back(ch);
        end
    endtask

    // One byte transfer. New values go out on the falling edge, and the
    // transfer is taken as done at the first rising edge that sees ready.
    // Random gaps drop valid for whole cycles before the byte goes out.
    task automatic send_byte(logic [7:0] value, logic mark);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            request_ch.valid <= 1'b0;
            @(negedge clk);
        end
        request_ch.valid     <= 1'b1;
        request_ch.data_byte <= value;
        request_ch.first     <= mark;
        @(posedge clk);
        while (!request_ch.ready) @(posedge clk);
    endtask

    // Sends the assembled request, marking its first byte when asked to.
    task automatic send_request(bit mark_first);
        for (int i = 0; i < request_bytes.size(); i++)
        begin
            send_byte(request_bytes[i], mark_first && i == 0);
            bytes_sent++;
        end
        request_bytes.delete();
    endtask

    initial
    begin
        int body_room;
        int kind;
        int pick;
        int n;
        int idx;
        int start_bytes;
        int start_verdicts;

        request_ch.valid     = 1'b0;
        request_ch.data_byte = '0;
        request_ch.first     = 1'b0;
        send_idle            = 12;
        recv_idle            = 54;
        bytes_sent           = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------------------------------------------------------
        // Directed requests, run with a lightly gapped sender and a slow
        // receiver.
        // ---------------------------------------------------------------

        // Right after reset the parser already sits at offset zero, so a
        // request without the first marker must still be parsed.
        put_text("GET /a HTTP/1.1~^~^");
        send_request(1'b0);

        // Plain request with an unrelated header.
        put_text("GET / HTTP/1.1~^Host: example~^~^");
        send_request(1'b1);

        // Both recognized headers, with two spaces before the type value.
        put_text("POST /up HTTP/1.1~^Content-Length: 12~^Content-Type:  text/plain~^~^");
        send_request(1'b1);

        // Mixed case names, leading zeros, and the last header of each kind wins.
        put_text("PUT /x H~^cOnTeNt-LeNgTh:5~^content-length:   000042~^");
        put_text("CONTENT-TYPE:a~^content-type: bb~^~^");
        send_request(1'b1);

        // Transfer-Encoding asks for a length even with a valid length present.
        put_text("POST /c H~^Transfer-Encoding: chunked~^Content-Length: 10~^~^");
        send_request(1'b1);

        // A bad length beats the length-required verdict.
        put_text("POST /c H~^transfer-encoding:~^Content-Length: 1a~^~^");
        send_request(1'b1);

        // Broken request lines: no space, empty method, empty target, and a
        // target without the second space.
        put_text("GET~^~^");
        send_request(1'b1);
        put_text(" / H~^~^");
        send_request(1'b1);
        put_text("GET  H~^~^");
        send_request(1'b1);
        put_text("GET /~^~^");
        send_request(1'b1);

        // Empty length values, with and without trailing spaces.
        put_text("GET / H~^Content-Length:~^~^");
        send_request(1'b1);
        put_text("GET / H~^Content-Length:   ~^~^");
        send_request(1'b1);

        // An over-long length saturates at the window size and is too large.
        put_text("GET / H~^Content-Length: 99999999~^~^");
        send_request(1'b1);

        // A body that exactly fills the rest of the window fits; one more
        // byte does not. The length field always has five digits here.
        put_text("POST /b H~^Content-Length: ");
        body_room = WINDOW_BYTES - (request_bytes.size() + 9);
        put_text($sformatf("%05d~^~^", body_room));
        send_request(1'b1);
        put_text($sformatf("POST /b H~^Content-Length: %05d~^~^", body_room + 1));
        send_request(1'b1);

        // Bare carriage returns count as plain content: inside the method and
        // the target, inside a header name (which then fails to match) and
        // inside the type value.
        put_text("GE~T /a~b H~^Conte~nt-Length: 4~^Content-Type: a~b~^X~: y~^~^");
        send_request(1'b1);
        // A bare CR right after the digits makes the length malformed.
        put_text("GET / H~^Content-Length: 4~~^~^");
        send_request(1'b1);

        // Lines without a colon are ignored, and a longer name does not match.
        put_text("GET / H~^Content-Length 5~^NoColonHere~^Transfer-Encoding-X: y~^~^");
        send_request(1'b1);

        // Content-Type with no value at all, then with only spaces.
        put_text("GET / H~^Content-Type:~^Content-Type:   ~^~^");
        send_request(1'b1);

        // A bare LF, then CR CR LF CR LF where the first CR is plain content.
        put_text("GET / H^x~~^~^");
        send_request(1'b1);

        // Bytes after a verdict are swallowed, a request cut short is
        // abandoned by the next first marker.
        put_text("GET / H~^~^trailing");
        send_request(1'b1);
        put_text("GET /p H~^Content-Len");
        send_request(1'b1);
        put_text("GET / H~^Content-Length: 0~^Content-Type: x/y~^~^");
        send_request(1'b1);

        // ---------------------------------------------------------------
        // Random requests in three idling modes: slow receiver, then slow
        // sender, then both at full speed.
        // ---------------------------------------------------------------
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle      = (mode == 0) ? 12 : (mode == 1) ? 54 : 0;
            recv_idle      = (mode == 0) ? 54 : (mode == 1) ? 12 : 0;
            start_bytes    = bytes_sent;
            start_verdicts = verdicts_seen;
            while (bytes_sent - start_bytes < RANDOM_BYTES_PER_MODE
                   || verdicts_seen - start_verdicts < VERDICTS_PER_MODE)
            begin
                kind = $urandom_range(99);
                if (kind < 12)
                begin
                    // Pure noise over the whole byte range, sometimes closed
                    // by a blank line so that it draws a verdict.
                    repeat ($urandom_range(1, 30))
                        request_bytes.push_back(8'($urandom_range(255)));
                    if ($urandom_range(1) == 1)
                        put_text("~^~^");
                end
                else
                begin
                    // Request line: method, target, version.
                    repeat ($urandom_range(1, 7))
                        request_bytes.push_back(8'($urandom_range("A", "Z")));
                    put_text(" /");
                    repeat ($urandom_range(0, 10))
                        request_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    put_text(" HTTP/1.1~^");
                    repeat ($urandom_range(0, 3))
                    begin
                        pick = $urandom_range(99);
                        if (pick < 30)
                        begin
                            // Length: mostly digits, sometimes none, sometimes
                            // with a stray character at the end.
                            put_name("Content-Length");
                            put_text(":");
                            put_fill(" ", $urandom_range(0, 2));
                            repeat ($urandom_range(0, 6))
                                request_bytes.push_back(8'($urandom_range("0", "9")));
                            if ($urandom_range(9) == 0)
                                request_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
                        end
                        else if (pick < 50)
                        begin
                            put_name("Content-Type");
                            put_text(":");
                            put_fill(" ", $urandom_range(0, 3));
                            repeat ($urandom_range(0, 15))
                                request_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                        end
                        else if (pick < 57)
                        begin
                            put_name("Transfer-Encoding");
                            put_text(": chunked");
                        end
                        else if (pick < 75)
                        begin
                            put_name(near_names[$urandom_range(5)]);
                            put_text(":");
                            put_fill(" ", $urandom_range(0, 2));
                            repeat ($urandom_range(0, 6))
                                request_bytes.push_back(8'($urandom_range("0", "9")));
                        end
                        else if (pick < 85)
                        begin
                            // A line with no colon in it.
                            repeat ($urandom_range(1, 12))
                                request_bytes.push_back(8'($urandom_range(8'h3B, 8'h7E)));
                        end
                        else
                        begin
                            repeat ($urandom_range(1, 10))
                                request_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
                            put_text(":");
                            repeat ($urandom_range(0, 8))
                                request_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                        end
                        put_text("~^");
                    end
                    put_text("~^");
                    if (kind < 27)
                    begin
                        // Damage a few bytes of an otherwise proper request.
                        repeat ($urandom_range(1, 3))
                        begin
                            idx = $urandom_range(request_bytes.size() - 1);
                            case ($urandom_range(3))
                                0:
                                    request_bytes[idx] = 8'($urandom_range(255));
                                1:
                                    request_bytes.insert(idx, CH_CR);
                                2:
                                    request_bytes.insert(idx, CH_SPACE);
                                default:
                                    request_bytes.delete(idx);
                            endcase
                        end
                        // Sometimes cut the tail off, so the request never ends
                        // and the next first marker abandons it.
                        if (kind < 20)
                        begin
                            n = $urandom_range(1, request_bytes.size() / 2);
                            repeat (n) void'(request_bytes.pop_back());
                        end
                    end
                end
                // Trailing bytes, swallowed when the verdict has already gone.
                if ($urandom_range(99) < 10)
                begin
                    repeat ($urandom_range(1, 5))
                        request_bytes.push_back(8'($urandom_range(255)));
                end
                // A few requests come without the first marker and are ignored
                // after a verdict, or run on into the unfinished one before.
                send_request($urandom_range(99) >= 3);
            end
        end

        @(negedge clk);
        request_ch.valid <= 1'b0;

        // Wait for every predicted verdict, then a little longer so that a
        // verdict nobody asked for would still be seen by the checker.
        while (pending_verdicts != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
